// File: rtl/core/lsa_pkg.sv
`timescale 1ns / 1ps
package lsa_pkg;

  localparam int TS_W   = 48;
  localparam int CNT_W  = 32;
  localparam int TIME_W = 32;
  localparam int SUM_W  = 64;
  localparam int MEAN_W = 48;
  localparam int CH_W   = 2;
  localparam int NUM_CH = 3;

  typedef logic [CH_W-1:0] lsa_ch_t;

  localparam lsa_ch_t CH_PROG_TMO   = 2'd0;
  localparam lsa_ch_t CH_PROG_NOTMO = 2'd1;
  localparam lsa_ch_t CH_TRIG       = 2'd2;

  localparam logic REQ_PROGRESS = 1'b0;
  localparam logic REQ_TRIGGER  = 1'b1;
  localparam logic PHASE_START  = 1'b0;
  localparam logic PHASE_END    = 1'b1;

  // Status of the mean divider as seen by the back end
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } lsa_div_stat_t;

endpackage

// File: rtl/core/lsa_front.sv
`timescale 1ns / 1ps
module lsa_front #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_req_type,
  input  logic                      in_phase,
  input  logic [lsa_pkg::TS_W-1:0]  in_timestamp,
  input  logic                      in_with_timeout,
  output logic                      in_full,
  input  logic                      q_full,
  output logic                      q_push,
  output lsa_pkg::lsa_ch_t          q_ch,
  output logic [SAMPLE_WIDTH-1:0]   q_dur
);
  import lsa_pkg::*;

  logic [TS_W-1:0] start_r [2];
  logic            accept;
  logic [TS_W-1:0] diff;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;

  // Elapsed ticks wrap at the timestamp width, then clamp to the sample width
  assign diff  = in_timestamp - start_r[in_req_type];
  assign q_dur = ((diff >> SAMPLE_WIDTH) != '0) ? '1 : SAMPLE_WIDTH'(diff);

  assign q_ch = (in_req_type == REQ_TRIGGER) ? CH_TRIG :
                (in_with_timeout ? CH_PROG_TMO : CH_PROG_NOTMO);

  assign q_push = accept & (in_phase == PHASE_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      start_r[1] <= '0;
    end else if (accept && in_phase == PHASE_START) begin
      start_r[in_req_type] <= in_timestamp;
    end
  end

endmodule

// File: rtl/core/lsa_fifo.sv
`timescale 1ns / 1ps
module lsa_fifo #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/core/lsa_div.sv
`timescale 1ns / 1ps
module lsa_div #(
  parameter int MEAN_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lsa_pkg::SUM_W-1:0]   dividend,
  input  logic [lsa_pkg::CNT_W-1:0]   divisor,
  output lsa_pkg::lsa_div_stat_t      stat,
  output logic [lsa_pkg::MEAN_W-1:0]  quot
);
  import lsa_pkg::*;

  localparam int NB  = SUM_W + MEAN_FRAC_BITS;
  localparam int CTW = $clog2(NB + 1);

  logic [NB-1:0]     n_r;
  logic [CNT_W-1:0]  dv_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MEAN_W-1:0] q_r;
  logic              ovf_r;
  logic [CTW-1:0]    cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;

  // One restoring step a cycle over the dividend with the fraction zeros appended
  assign trial   = {rem_r, n_r[NB-1]};
  assign diff    = trial - {1'b0, dv_r};
  assign ge      = (trial >= {1'b0, dv_r});
  assign rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quot      = q_r;

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      n_r   <= NB'(dividend) << MEAN_FRAC_BITS;
      dv_r  <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      n_r   <= n_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[MEAN_W-2:0], ge};
      // quotient bits beyond the mean width mean saturation
      ovf_r <= ovf_r | q_r[MEAN_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CTW'(NB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/lsa_back.sv
`timescale 1ns / 1ps
module lsa_back #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int MEAN_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lsa_pkg::lsa_ch_t            q_ch,
  input  logic [SAMPLE_WIDTH-1:0]     q_dur,
  output logic                        q_pop,
  output logic                        div_start,
  output logic [lsa_pkg::SUM_W-1:0]   div_dividend,
  output logic [lsa_pkg::CNT_W-1:0]   div_divisor,
  input  lsa_pkg::lsa_div_stat_t      div_stat,
  input  logic [lsa_pkg::MEAN_W-1:0]  div_quot,
  output logic                        out_empty,
  input  logic                        out_pop,
  output lsa_pkg::lsa_ch_t            out_channel,
  output logic [lsa_pkg::CNT_W-1:0]   out_sample_count,
  output logic [lsa_pkg::TIME_W-1:0]  out_min_time,
  output logic [lsa_pkg::TIME_W-1:0]  out_max_time,
  output logic [lsa_pkg::SUM_W-1:0]   out_total_time,
  output logic [lsa_pkg::MEAN_W-1:0]  out_mean_time,
  output logic [lsa_pkg::SUM_W-1:0]   out_sq_dev_sum
);
  import lsa_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = MEAN_FRAC_BITS;
  localparam int DW    = (SW + F > MEAN_W) ? SW + F : MEAN_W;
  localparam int CHUNK = 24;
  localparam int NC    = (DW + CHUNK - 1) / CHUNK;
  localparam int MW    = NC * CHUNK;
  localparam int AW    = (2 * MW > 2 * F + SUM_W) ? 2 * MW : 2 * F + SUM_W;
  localparam int IW    = $clog2(NC);
  localparam int SHW   = $clog2(2 * NC - 1);

  typedef logic [MW:0]   ext_t;
  typedef logic [AW-1:0] acc_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_DRN  = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r  [NUM_CH];
  logic [SW-1:0]     min_r  [NUM_CH];
  logic [SW-1:0]     max_r  [NUM_CH];
  logic [SUM_W-1:0]  sum_r  [NUM_CH];
  logic [MEAN_W-1:0] mean_r [NUM_CH];
  logic [SUM_W-1:0]  dev_r  [NUM_CH];

  lsa_ch_t           ch_r;
  logic [SW-1:0]     d_r;
  logic [MEAN_W-1:0] oldm_r;
  logic [MW-1:0]     a_r;
  logic [MW-1:0]     b_r;
  logic              an_r;
  logic              bn_r;
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     j_r;
  logic [2*CHUNK-1:0] pp_r;
  logic [SHW-1:0]    sh_r;
  logic              pp_vld_r;
  acc_t              acc_r;

  logic              out_vld_r;
  lsa_ch_t           o_ch_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic [TIME_W-1:0] o_min_r;
  logic [TIME_W-1:0] o_max_r;
  logic [SUM_W-1:0]  o_sum_r;
  logic [MEAN_W-1:0] o_mean_r;
  logic [SUM_W-1:0]  o_dev_r;

  logic [CNT_W-1:0]  cur_cnt;
  logic [SW-1:0]     cur_min;
  logic [SW-1:0]     cur_max;
  logic [SUM_W-1:0]  cur_sum;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SW-1:0]     min_nxt;
  logic [SW-1:0]     max_nxt;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_nxt;

  logic [MEAN_W-1:0] newm;
  ext_t              dev_a;
  ext_t              dev_b;
  logic [2*CHUNK-1:0] pp_c;
  acc_t              acc_nxt;
  logic              acc_ovf;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  cur_dev;
  logic [SUM_W:0]    dev_sum;
  logic [SUM_W-1:0]  dev_nxt;
  logic              emit_ok;

  // Sign and magnitude of (t << F) - m
  function automatic ext_t dev_mag(input logic [SW-1:0] t, input logic [MEAN_W-1:0] m);
    ext_t tf;
    ext_t mm;
    ext_t df;
    logic neg;
    tf = ext_t'(t) << F;
    mm = ext_t'(m);
    if (tf >= mm) begin
      df  = tf - mm;
      neg = 1'b0;
    end else begin
      df  = mm - tf;
      neg = 1'b1;
    end
    return {neg, df[MW-1:0]};
  endfunction

  // Count, min, max and sum of the channel at the head of the queue
  assign cur_cnt = cnt_r[q_ch];
  assign cur_min = min_r[q_ch];
  assign cur_max = max_r[q_ch];
  assign cur_sum = sum_r[q_ch];
  assign cnt_nxt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
  assign min_nxt = (cur_cnt == '0 || q_dur < cur_min) ? q_dur : cur_min;
  assign max_nxt = (q_dur > cur_max) ? q_dur : cur_max;
  assign sum_ext = {1'b0, cur_sum} + (SUM_W + 1)'(q_dur);
  assign sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  assign q_pop        = (state_r == S_IDLE) && !q_empty;
  assign div_start    = q_pop;
  assign div_dividend = sum_nxt;
  assign div_divisor  = cnt_nxt;

  assign newm  = div_stat.ovf ? '1 : div_quot;
  assign dev_a = dev_mag(d_r, oldm_r);
  assign dev_b = dev_mag(d_r, newm);

  // One chunk product a cycle; shift and add it the cycle after
  assign pp_c    = a_r[i_r * CHUNK +: CHUNK] * b_r[j_r * CHUNK +: CHUNK];
  assign acc_nxt = acc_r + (acc_t'(pp_r) << (CHUNK * sh_r));

  assign acc_ovf = |(acc_r >> (2 * F + SUM_W));
  assign prod    = acc_ovf ? '1 : acc_r[2 * F +: SUM_W];
  assign cur_dev = dev_r[ch_r];
  assign dev_sum = {1'b0, cur_dev} + {1'b0, prod};
  assign dev_nxt = (an_r != bn_r) ? ((cur_dev >= prod) ? cur_dev - prod : '0) :
                   (dev_sum[SUM_W] ? '1 : dev_sum[SUM_W-1:0]);

  assign emit_ok = !out_vld_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_MUL;
      S_MUL:  if (i_r == IW'(NC - 1) && j_r == IW'(NC - 1)) state_nxt = S_DRN;
      S_DRN:  state_nxt = S_FIN;
      S_FIN:  state_nxt = S_EMIT;
      S_EMIT: if (emit_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CH; k++) begin
        cnt_r[k]  <= '0;
        min_r[k]  <= '0;
        max_r[k]  <= '0;
        sum_r[k]  <= '0;
        mean_r[k] <= '0;
        dev_r[k]  <= '0;
      end
    end else begin
      if (q_pop) begin
        cnt_r[q_ch] <= cnt_nxt;
        min_r[q_ch] <= min_nxt;
        max_r[q_ch] <= max_nxt;
        sum_r[q_ch] <= sum_nxt;
      end
      if (state_r == S_DIV && div_stat.done) begin
        mean_r[ch_r] <= newm;
      end
      if (state_r == S_FIN) begin
        dev_r[ch_r] <= dev_nxt;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ch_r   <= q_ch;
      d_r    <= q_dur;
      oldm_r <= mean_r[q_ch];
    end
    if (state_r == S_DIV && div_stat.done) begin
      an_r <= dev_a[MW];
      a_r  <= dev_a[MW-1:0];
      bn_r <= dev_b[MW];
      b_r  <= dev_b[MW-1:0];
      i_r  <= '0;
      j_r  <= '0;
      acc_r <= '0;
    end
    if (state_r == S_MUL) begin
      pp_r <= pp_c;
      sh_r <= SHW'(i_r) + SHW'(j_r);
      if (pp_vld_r) begin
        acc_r <= acc_nxt;
      end
      if (j_r == IW'(NC - 1)) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (state_r == S_DRN) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= (state_r == S_MUL);
    end
  end

  // Output register: holds a result while the back end starts the next item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_EMIT && emit_ok) begin
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && emit_ok) begin
      o_ch_r   <= ch_r;
      o_cnt_r  <= cnt_r[ch_r];
      o_min_r  <= TIME_W'(min_r[ch_r]);
      o_max_r  <= TIME_W'(max_r[ch_r]);
      o_sum_r  <= sum_r[ch_r];
      o_mean_r <= mean_r[ch_r];
      o_dev_r  <= dev_r[ch_r];
    end
  end

  assign out_empty        = ~out_vld_r;
  assign out_channel      = o_ch_r;
  assign out_sample_count = o_cnt_r;
  assign out_min_time     = o_min_r;
  assign out_max_time     = o_max_r;
  assign out_total_time   = o_sum_r;
  assign out_mean_time    = o_mean_r;
  assign out_sq_dev_sum   = o_dev_r;

endmodule

// File: rtl/core/latency_stats_accumulator.sv
`timescale 1ns / 1ps
// Event latency statistics. A start item (phase 0) records its timestamp for
// its class; an end item (phase 1) measures the elapsed ticks and updates
// one of three channels (progress with timeout, progress without timeout,
// trigger): count, min, max, sum, Q.MEAN_FRAC_BITS mean and the Welford
// squared-deviation sum, then presents that channel's statistics as one
// result. The front end takes end items into a two-entry queue while the
// back end works; each end item occupies the back end through the
// one-bit-per-cycle mean divider and the 24x24 chunk multiplier that forms
// the deviation product over NC 24-bit chunks per operand (NC is 2 at the
// defaults). A finished result waits in an output register until popped;
// the next item can start meanwhile.
module latency_stats_accumulator #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int MEAN_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_req_type,
  input  logic                        in_phase,
  input  logic [lsa_pkg::TS_W-1:0]    in_timestamp,
  input  logic                        in_with_timeout,
  output logic                        out_empty,
  input  logic                        out_pop,
  output lsa_pkg::lsa_ch_t            out_channel,
  output logic [lsa_pkg::CNT_W-1:0]   out_sample_count,
  output logic [lsa_pkg::TIME_W-1:0]  out_min_time,
  output logic [lsa_pkg::TIME_W-1:0]  out_max_time,
  output logic [lsa_pkg::SUM_W-1:0]   out_total_time,
  output logic [lsa_pkg::MEAN_W-1:0]  out_mean_time,
  output logic [lsa_pkg::SUM_W-1:0]   out_sq_dev_sum
);
  import lsa_pkg::*;

  localparam int QW = SAMPLE_WIDTH + CH_W;

  logic                    q_full;
  logic                    q_push;
  lsa_ch_t                 q_wr_ch;
  logic [SAMPLE_WIDTH-1:0] q_wr_dur;
  logic [QW-1:0]           q_rd_data;
  logic                    q_empty;
  logic                    q_pop;
  logic                    div_start;
  logic [SUM_W-1:0]        div_dividend;
  logic [CNT_W-1:0]        div_divisor;
  lsa_div_stat_t           div_stat;
  logic [MEAN_W-1:0]       div_quot;

  lsa_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_req_type     (in_req_type),
    .in_phase        (in_phase),
    .in_timestamp    (in_timestamp),
    .in_with_timeout (in_with_timeout),
    .in_full         (in_full),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ch            (q_wr_ch),
    .q_dur           (q_wr_dur)
  );

  lsa_fifo #(
    .W (QW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({q_wr_ch, q_wr_dur}),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  lsa_div #(
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  lsa_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_ch             (q_rd_data[QW-1:SAMPLE_WIDTH]),
    .q_dur            (q_rd_data[SAMPLE_WIDTH-1:0]),
    .q_pop            (q_pop),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_stat         (div_stat),
    .div_quot         (div_quot),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_channel      (out_channel),
    .out_sample_count (out_sample_count),
    .out_min_time     (out_min_time),
    .out_max_time     (out_max_time),
    .out_total_time   (out_total_time),
    .out_mean_time    (out_mean_time),
    .out_sq_dev_sum   (out_sq_dev_sum)
  );

endmodule

// File: rtl/core/lsa_checker.sv
`timescale 1ns / 1ps
module lsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input lsa_pkg::lsa_ch_t            out_channel,
  input logic [lsa_pkg::CNT_W-1:0]   out_sample_count,
  input logic [lsa_pkg::TIME_W-1:0]  out_max_time,
  input logic [lsa_pkg::SUM_W-1:0]   out_total_time,
  input logic [lsa_pkg::MEAN_W-1:0]  out_mean_time,
  input logic [lsa_pkg::SUM_W-1:0]   out_sq_dev_sum
);

  // Reset drains both queues
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not drained after reset");

  // A waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_channel) &&
      $stable(out_sample_count) && $stable(out_total_time) &&
      $stable(out_mean_time) && $stable(out_sq_dev_sum))
    else $error("result changed while waiting");

  // Every result follows at least one sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_sample_count != '0)
    else $error("result with zero sample count");

  // The sum of durations never falls below the largest one
  a_sum_covers_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_total_time >= lsa_pkg::SUM_W'(out_max_time))
    else $error("total below maximum duration");

endmodule

bind latency_stats_accumulator lsa_checker u_lsa_checker (.*);
